[src/fpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared constants and word types for the farthest-point representative picker.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int MAX_DIM     = 16;
  localparam int MAX_REPS    = 16;
  localparam int STORE_DEPTH = MAX_POINTS * MAX_DIM;

  localparam int COORD_W = 32;
  localparam int DIST_W  = 64;
  localparam int CC_W    = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int IDX_W   = $clog2(MAX_POINTS);
  localparam int NPTS_W  = $clog2(MAX_POINTS + 1);
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int CFG_W   = 5;
  localparam int CENT_W  = $clog2(MAX_DIM + 1);

  localparam logic [1:0] CFG_METRIC    = 2'd0;
  localparam logic [1:0] CFG_REP_COUNT = 2'd1;
  localparam logic [1:0] CFG_DIMS      = 2'd2;

  localparam logic [1:0] METRIC_SQ   = 2'd0;
  localparam logic [1:0] METRIC_EUCL = 2'd1;
  localparam logic [1:0] METRIC_MANH = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord;
    logic                      is_centroid;
    logic                      last;
  } in_word_t;

  typedef struct packed {
    logic [9:0] rep_index;
    logic       last_rep;
  } out_word_t;

endpackage

[src/farthest_point_representatives.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// farthest_point_representatives
// Loads a centroid and points one coordinate word per cycle, then picks
// representative point indices by farthest-point sampling.
// ----------------------------------------------------------------------------
// Loading takes one coordinate word per cycle while busy is low. After the last
// word: a division of the word count by the dimensions, a check, then per pass a
// setup step and, per point and coordinate, read, subtract, multiply, accumulate,
// then a square root if Euclidean and an update; each pass ends in one pick. With
// too few points, indices stream out one per cycle. Results cannot stall.
// Synchronous reset clears control and sets default config; stores stay undefined.
module farthest_point_representatives (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  fpr_pkg::in_word_t             in_word,
  output logic                          out_valid,
  output fpr_pkg::out_word_t            out_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [fpr_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CC_W   = fpr_pkg::CC_W;
  localparam int ADDR_W = fpr_pkg::ADDR_W;
  localparam int IDX_W  = fpr_pkg::IDX_W;
  localparam int NPTS_W = fpr_pkg::NPTS_W;
  localparam int DIM_W  = fpr_pkg::DIM_W;
  localparam int CFG_W  = fpr_pkg::CFG_W;
  localparam int CENT_W = fpr_pkg::CENT_W;
  localparam int DW     = fpr_pkg::DIST_W;
  localparam int CW     = fpr_pkg::COORD_W;
  localparam int PASS_W = $clog2(fpr_pkg::MAX_REPS);
  localparam int DIVC_W = $clog2(CC_W);
  localparam int SQ_N   = DW / 2;
  localparam int SQC_W  = $clog2(SQ_N);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DIV  = 11'b000_0000_0010,
    S_CHK  = 11'b000_0000_0100,
    S_ALL  = 11'b000_0000_1000,
    S_BASE = 11'b000_0001_0000,
    S_RD   = 11'b000_0010_0000,
    S_SUB  = 11'b000_0100_0000,
    S_MUL  = 11'b000_1000_0000,
    S_ACC  = 11'b001_0000_0000,
    S_SQRT = 11'b010_0000_0000,
    S_UPD  = 11'b100_0000_0000
  } state_t;

  logic [CW-1:0] point_mem [fpr_pkg::STORE_DEPTH];
  logic [CW-1:0] cent_mem  [fpr_pkg::MAX_DIM];
  logic [DW-1:0] min_mem   [fpr_pkg::MAX_POINTS];

  state_t               state_r, state_nxt;
  logic [1:0]           metric_r, metric_nxt;
  logic [CFG_W-1:0]     rep_count_r, rep_count_nxt;
  logic [CFG_W-1:0]     dims_r, dims_nxt;
  logic [CC_W-1:0]      coord_count_r, coord_count_nxt;
  logic [CENT_W-1:0]    cent_count_r, cent_count_nxt;
  logic [CENT_W-1:0]    div_rem_r, div_rem_nxt;
  logic [CC_W-1:0]      div_quo_r, div_quo_nxt;
  logic [DIVC_W-1:0]    div_cnt_r, div_cnt_nxt;
  logic [NPTS_W-1:0]    npts_r, npts_nxt;
  logic [PASS_W-1:0]    pass_r, pass_nxt;
  logic [IDX_W-1:0]     j_r, j_nxt;
  logic [DIM_W-1:0]     d_r, d_nxt;
  logic [ADDR_W-1:0]    cand_addr_r, cand_addr_nxt;
  logic [ADDR_W-1:0]    ref_base_r, ref_base_nxt;
  logic [ADDR_W-1:0]    ref_addr_r, ref_addr_nxt;
  logic [IDX_W-1:0]     pick_prev_r, pick_prev_nxt;
  logic [CW-1:0]        ad_r, ad_nxt;
  logic [DW-1:0]        term_r, term_nxt;
  logic [DW-1:0]        acc_r, acc_nxt;
  logic [DW-1:0]        sq_val_r, sq_val_nxt;
  logic [DW-1:0]        sq_root_r, sq_root_nxt;
  logic [DW-1:0]        sq_bit_r, sq_bit_nxt;
  logic [SQC_W-1:0]     sq_cnt_r, sq_cnt_nxt;
  logic [DW-1:0]        maxd_r, maxd_nxt;
  logic [IDX_W-1:0]     maxi_r, maxi_nxt;
  logic                 out_valid_r, out_valid_nxt;
  fpr_pkg::out_word_t   out_word_r, out_word_nxt;

  logic [CW-1:0]        pa_q_r, pb_q_r, cent_q_r;
  logic [DW-1:0]        md_q_r;

  logic                 pw_en, cw_en, mw_en;
  logic [DW-1:0]        mw_data;

  logic [CFG_W-1:0]     nd_eff, nreps_eff;
  logic [CC_W-1:0]      cc_inc;
  logic [CENT_W:0]      div_shift;
  logic [NPTS_W-1:0]    npts_w;
  logic [IDX_W+CFG_W-1:0] base_prod;
  logic [CW-1:0]        ref_val;
  logic [CW:0]          diff;
  logic [DW:0]          sum_w;
  logic [DW-1:0]        sq_try;
  logic [DW-1:0]        dist_w, newmin_w, cand_w;
  logic                 better_w;
  logic [IDX_W-1:0]     pick_w;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (pw_en) begin
      point_mem[coord_count_r[ADDR_W-1:0]] <= in_word.coord;
    end
    if (cw_en) begin
      cent_mem[cent_count_r[DIM_W-1:0]] <= in_word.coord;
    end
    if (mw_en) begin
      min_mem[j_r] <= mw_data;
    end
    pa_q_r   <= point_mem[cand_addr_r];
    pb_q_r   <= point_mem[ref_addr_r];
    cent_q_r <= cent_mem[d_r];
    md_q_r   <= min_mem[j_r];
  end

  always_comb begin
    nd_eff = dims_r;
    if (dims_r == '0) begin
      nd_eff = CFG_W'(1);
    end else if (dims_r > CFG_W'(fpr_pkg::MAX_DIM)) begin
      nd_eff = CFG_W'(fpr_pkg::MAX_DIM);
    end
    nreps_eff = rep_count_r;
    if (rep_count_r == '0) begin
      nreps_eff = CFG_W'(1);
    end else if (rep_count_r > CFG_W'(fpr_pkg::MAX_REPS)) begin
      nreps_eff = CFG_W'(fpr_pkg::MAX_REPS);
    end
  end

  always_comb begin
    cc_inc    = coord_count_r + CC_W'(1);
    div_shift = {div_rem_r, div_quo_r[CC_W-1]};
    npts_w    = (div_quo_r > CC_W'(fpr_pkg::MAX_POINTS)) ? NPTS_W'(fpr_pkg::MAX_POINTS)
                                                        : div_quo_r[NPTS_W-1:0];
    base_prod = pick_prev_r * nd_eff;
    ref_val   = (pass_r == '0) ? cent_q_r : pb_q_r;
    diff      = {ref_val[CW-1], ref_val} - {pa_q_r[CW-1], pa_q_r};
    sum_w     = {1'b0, acc_r} + {1'b0, term_r};
    sq_try    = sq_root_r + sq_bit_r;
    dist_w    = (metric_r == fpr_pkg::METRIC_EUCL) ? sq_root_r : acc_r;
    newmin_w  = (pass_r == PASS_W'(1) || dist_w < md_q_r) ? dist_w : md_q_r;
    cand_w    = (pass_r == '0) ? dist_w : newmin_w;
    better_w  = (cand_w > maxd_r);
    pick_w    = better_w ? j_r : maxi_r;
  end

  always_comb begin
    state_nxt       = state_r;
    metric_nxt      = metric_r;
    rep_count_nxt   = rep_count_r;
    dims_nxt        = dims_r;
    coord_count_nxt = coord_count_r;
    cent_count_nxt  = cent_count_r;
    div_rem_nxt     = div_rem_r;
    div_quo_nxt     = div_quo_r;
    div_cnt_nxt     = div_cnt_r;
    npts_nxt        = npts_r;
    pass_nxt        = pass_r;
    j_nxt           = j_r;
    d_nxt           = d_r;
    cand_addr_nxt   = cand_addr_r;
    ref_base_nxt    = ref_base_r;
    ref_addr_nxt    = ref_addr_r;
    pick_prev_nxt   = pick_prev_r;
    ad_nxt          = ad_r;
    term_nxt        = term_r;
    acc_nxt         = acc_r;
    sq_val_nxt      = sq_val_r;
    sq_root_nxt     = sq_root_r;
    sq_bit_nxt      = sq_bit_r;
    sq_cnt_nxt      = sq_cnt_r;
    maxd_nxt        = maxd_r;
    maxi_nxt        = maxi_r;
    out_valid_nxt   = 1'b0;
    out_word_nxt    = out_word_r;
    pw_en           = 1'b0;
    cw_en           = 1'b0;
    mw_en           = 1'b0;
    mw_data         = newmin_w;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fpr_pkg::CFG_METRIC:    metric_nxt    = cfg_data[1:0];
        fpr_pkg::CFG_REP_COUNT: rep_count_nxt = cfg_data;
        fpr_pkg::CFG_DIMS:      dims_nxt      = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_word.is_centroid) begin
            if (cent_count_r < CENT_W'(fpr_pkg::MAX_DIM)) begin
              cw_en          = 1'b1;
              cent_count_nxt = cent_count_r + CENT_W'(1);
            end
          end else if (coord_count_r < CC_W'(fpr_pkg::STORE_DEPTH)) begin
            pw_en           = 1'b1;
            coord_count_nxt = cc_inc;
          end
          if (in_word.last) begin
            div_quo_nxt     = coord_count_nxt;
            div_rem_nxt     = '0;
            div_cnt_nxt     = '0;
            coord_count_nxt = '0;
            cent_count_nxt  = '0;
            state_nxt       = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_shift >= {1'b0, nd_eff}) begin
          div_rem_nxt = CENT_W'(div_shift - {1'b0, nd_eff});
          div_quo_nxt = {div_quo_r[CC_W-2:0], 1'b1};
        end else begin
          div_rem_nxt = div_shift[CENT_W-1:0];
          div_quo_nxt = {div_quo_r[CC_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + DIVC_W'(1);
        if (div_cnt_r == DIVC_W'(CC_W - 1)) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        npts_nxt = npts_w;
        j_nxt    = '0;
        pass_nxt = '0;
        if (npts_w == '0) begin
          state_nxt = S_IDLE;
        end else if (NPTS_W'(nreps_eff) >= npts_w) begin
          state_nxt = S_ALL;
        end else begin
          state_nxt = S_BASE;
        end
      end
      S_ALL: begin
        out_valid_nxt          = 1'b1;
        out_word_nxt.rep_index = j_r;
        out_word_nxt.last_rep  = (NPTS_W'(j_r) == npts_r - NPTS_W'(1));
        j_nxt                  = j_r + IDX_W'(1);
        if (NPTS_W'(j_r) == npts_r - NPTS_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_BASE: begin
        ref_base_nxt  = base_prod[ADDR_W-1:0];
        ref_addr_nxt  = base_prod[ADDR_W-1:0];
        cand_addr_nxt = '0;
        j_nxt         = '0;
        d_nxt         = '0;
        acc_nxt       = '0;
        maxd_nxt      = '0;
        maxi_nxt      = '0;
        state_nxt     = S_RD;
      end
      S_RD: begin
        state_nxt = S_SUB;
      end
      S_SUB: begin
        ad_nxt    = diff[CW] ? CW'(-diff) : diff[CW-1:0];
        state_nxt = S_MUL;
      end
      S_MUL: begin
        term_nxt  = metric_r[1] ? DW'(ad_r) : ad_r * ad_r;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt       = sum_w[DW] ? '1 : sum_w[DW-1:0];
        cand_addr_nxt = cand_addr_r + ADDR_W'(1);
        ref_addr_nxt  = ref_addr_r + ADDR_W'(1);
        d_nxt         = d_r + DIM_W'(1);
        if (CFG_W'(d_r) == nd_eff - CFG_W'(1)) begin
          if (metric_r == fpr_pkg::METRIC_EUCL) begin
            sq_val_nxt  = acc_nxt;
            sq_root_nxt = '0;
            sq_bit_nxt  = DW'(1) << (DW - 2);
            sq_cnt_nxt  = '0;
            state_nxt   = S_SQRT;
          end else begin
            state_nxt = S_UPD;
          end
        end else begin
          state_nxt = S_RD;
        end
      end
      S_SQRT: begin
        if (sq_val_r >= sq_try) begin
          sq_val_nxt  = sq_val_r - sq_try;
          sq_root_nxt = (sq_root_r >> 1) + sq_bit_r;
        end else begin
          sq_root_nxt = sq_root_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
        sq_cnt_nxt = sq_cnt_r + SQC_W'(1);
        if (sq_cnt_r == SQC_W'(SQ_N - 1)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        mw_en = (pass_r != '0);
        if (better_w) begin
          maxd_nxt = cand_w;
          maxi_nxt = j_r;
        end
        d_nxt        = '0;
        acc_nxt      = '0;
        ref_addr_nxt = ref_base_r;
        j_nxt        = j_r + IDX_W'(1);
        state_nxt    = S_RD;
        if (NPTS_W'(j_r) == npts_r - NPTS_W'(1)) begin
          out_valid_nxt          = 1'b1;
          out_word_nxt.rep_index = pick_w;
          out_word_nxt.last_rep  = (CFG_W'(pass_r) == nreps_eff - CFG_W'(1));
          pick_prev_nxt          = pick_w;
          pass_nxt               = pass_r + PASS_W'(1);
          if (CFG_W'(pass_r) == nreps_eff - CFG_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_BASE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      metric_r      <= fpr_pkg::METRIC_SQ;
      rep_count_r   <= CFG_W'(4);
      dims_r        <= CFG_W'(2);
      coord_count_r <= '0;
      cent_count_r  <= '0;
      out_valid_r   <= 1'b0;
      pick_prev_r   <= '0;
    end else begin
      state_r       <= state_nxt;
      metric_r      <= metric_nxt;
      rep_count_r   <= rep_count_nxt;
      dims_r        <= dims_nxt;
      coord_count_r <= coord_count_nxt;
      cent_count_r  <= cent_count_nxt;
      out_valid_r   <= out_valid_nxt;
      pick_prev_r   <= pick_prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_rem_r   <= div_rem_nxt;
    div_quo_r   <= div_quo_nxt;
    div_cnt_r   <= div_cnt_nxt;
    npts_r      <= npts_nxt;
    pass_r      <= pass_nxt;
    j_r         <= j_nxt;
    d_r         <= d_nxt;
    cand_addr_r <= cand_addr_nxt;
    ref_base_r  <= ref_base_nxt;
    ref_addr_r  <= ref_addr_nxt;
    ad_r        <= ad_nxt;
    term_r      <= term_nxt;
    acc_r       <= acc_nxt;
    sq_val_r    <= sq_val_nxt;
    sq_root_r   <= sq_root_nxt;
    sq_bit_r    <= sq_bit_nxt;
    sq_cnt_r    <= sq_cnt_nxt;
    maxd_r      <= maxd_nxt;
    maxi_r      <= maxi_nxt;
    out_word_r  <= out_word_nxt;
  end

  a_last_word_starts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_word.last |=> busy)
    else $error("last word did not start selection");

  a_last_rep_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last_rep |=> !out_valid)
    else $error("word strobed after final representative");

  a_counts_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> coord_count_r == '0 && cent_count_r == '0)
    else $error("load counters not cleared at selection");

  a_strobe_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word strobed without a selection in progress");

endmodule
